@@ rtl/free_block_fit_selector_assert.svh @@
// Assertion macros for the free block fit selector.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef FREE_BLOCK_FIT_SELECTOR_ASSERT_SVH
`define FREE_BLOCK_FIT_SELECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FBFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FBFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FBFS_ASSERT_IMP(lbl, ante, cons, msg)
`define FBFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/fbfs_pkg.sv @@
// Shared types and constants of the free block fit selector.
// No dependencies.
`timescale 1ns / 1ps

package fbfs_pkg;

  localparam int MAX_BLOCKS_DEF  = 64;
  localparam int ALIGN_BYTES_DEF = 16;

  localparam int SIZE_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int IDX_IN_W  = 6;
  localparam int LEN_IN_W  = 7;
  localparam int IDX_OUT_W = 6;
  localparam int OP_W      = 2;
  localparam int POL_W     = 2;

  // input tdata layout, lowest bit first
  localparam int EIDX_LSB  = 0;
  localparam int ESIZE_LSB = EIDX_LSB + IDX_IN_W;
  localparam int EFREE_LSB = ESIZE_LSB + SIZE_W;
  localparam int EADDR_LSB = EFREE_LSB + 1;
  localparam int NLEN_LSB  = EADDR_LSB + ADDR_W;
  localparam int REQ_LSB   = NLEN_LSB + LEN_IN_W;
  localparam int IN_USED_W = REQ_LSB + SIZE_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_LENGTH = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              usable;  // free and aligned
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic done;
    logic aligned;
  } align_res_t;

endpackage

@@ rtl/free_block_fit_selector.sv @@
// Top level of the free block fit selector: stream ports, table, alignment unit
// and sequencer. Uses fbfs_pkg, fbfs_align, fbfs_table, fbfs_ctrl and the assert macros.
`timescale 1ns / 1ps

// Keeps a table of MAX_BLOCKS entries (size, free flag, alignment of the payload
// address) and picks a block for a find transaction by first, next, best or worst
// fit. One transaction at a time: a set-length or unused opcode is handled when it
// is accepted; a write entry also passes through ST_ALIGN for the registered alignment
// check of the payload address before the table write. A find
// reads the table memory one entry per cycle through its single read port (first
// and next fit stop at the first candidate), and its result then waits for
// m_axis_tready. Write the policy register through cfg_we_i only while the block is
// idle; the block itself does not enforce this.
module free_block_fit_selector #(
  parameter int MAX_BLOCKS  = fbfs_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_BYTES = fbfs_pkg::ALIGN_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fbfs_pkg::POL_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index, entry_size, entry_free, entry_payload_addr, new_length, request_size
  input  logic [fbfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [fbfs_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // chosen_index
  output logic [fbfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // found
  output logic                             m_axis_tuser
);

`include "free_block_fit_selector_assert.svh"

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int LEN_W = $clog2(MAX_BLOCKS + 1);

  fbfs_pkg::align_res_t           align_res;
  fbfs_pkg::entry_t               tbl_wdata, tbl_rdata;
  logic                           align_start, tbl_we;
  logic [fbfs_pkg::ADDR_W-1:0]    align_addr;
  logic [IDX_W-1:0]               tbl_waddr, tbl_raddr;
  logic [fbfs_pkg::IDX_OUT_W-1:0] chosen_index;

  fbfs_align #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(align_start),
    .addr_i (align_addr),
    .res_o  (align_res)
  );

  fbfs_table #(
    .DEPTH(MAX_BLOCKS),
    .AW   (IDX_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  fbfs_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .IDX_W     (IDX_W),
    .LEN_W     (LEN_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (s_axis_tuser),
    .entry_index_i (s_axis_tdata[fbfs_pkg::EIDX_LSB +: fbfs_pkg::IDX_IN_W]),
    .entry_size_i  (s_axis_tdata[fbfs_pkg::ESIZE_LSB +: fbfs_pkg::SIZE_W]),
    .entry_free_i  (s_axis_tdata[fbfs_pkg::EFREE_LSB]),
    .entry_addr_i  (s_axis_tdata[fbfs_pkg::EADDR_LSB +: fbfs_pkg::ADDR_W]),
    .new_length_i  (s_axis_tdata[fbfs_pkg::NLEN_LSB +: fbfs_pkg::LEN_IN_W]),
    .request_size_i(s_axis_tdata[fbfs_pkg::REQ_LSB +: fbfs_pkg::SIZE_W]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .found_o       (m_axis_tuser),
    .chosen_index_o(chosen_index),
    .align_start_o (align_start),
    .align_addr_o  (align_addr),
    .align_res_i   (align_res),
    .tbl_we_o      (tbl_we),
    .tbl_waddr_o   (tbl_waddr),
    .tbl_wdata_o   (tbl_wdata),
    .tbl_raddr_o   (tbl_raddr),
    .tbl_rdata_i   (tbl_rdata)
  );

  assign m_axis_tdata = fbfs_pkg::OUT_TDATA_W'(chosen_index);

  `FBFS_ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `FBFS_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !m_axis_tuser, chosen_index == '0, "miss with nonzero index")
  `FBFS_ASSERT_IMP(a_idx_range, m_axis_tvalid && m_axis_tuser, 32'(chosen_index) < 32'(MAX_BLOCKS), "index beyond table")
  `FBFS_ASSERT_NXT(a_find_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == fbfs_pkg::OP_FIND, !s_axis_tready, "ready right after find")

endmodule

@@ rtl/fbfs_align.sv @@
// Alignment check of a payload address against ALIGN_BYTES, with a registered result.
// Mask for powers of two, otherwise a low-bit mask plus a divisibility test of the
// odd factor by multiplication with its inverse modulo 2^32. Uses fbfs_pkg.
`timescale 1ns / 1ps

module fbfs_align #(
  parameter int ALIGN_BYTES = fbfs_pkg::ALIGN_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fbfs_pkg::ADDR_W-1:0] addr_i,
  output fbfs_pkg::align_res_t        res_o
);

  localparam bit IS_POW2 = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;

  function automatic int trail_zeros(input int val);
    int v;
    int n;
    v = val;
    n = 0;
    while (v != 0 && (v & 1) == 0) begin
      v = v >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [fbfs_pkg::ADDR_W-1:0] odd_inverse(
      input logic [fbfs_pkg::ADDR_W-1:0] odd);
    logic [fbfs_pkg::ADDR_W-1:0] x;
    x = odd;
    for (int k = 0; k < 5; k++) begin
      x = x * (fbfs_pkg::ADDR_W'(2) - odd * x);
    end
    return x;
  endfunction

  logic done_q, aligned_q, aligned_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    aligned_q <= aligned_d;
  end

  generate
    if (IS_POW2) begin : g_mask
      localparam logic [fbfs_pkg::ADDR_W-1:0] MASK = fbfs_pkg::ADDR_W'(ALIGN_BYTES - 1);

      assign aligned_d = (addr_i & MASK) == '0;
    end else begin : g_inverse
      // ALIGN_BYTES = 2^TZ * ODD; a multiple of ODD times its inverse stays at or below LIMIT
      localparam int TZ  = trail_zeros(ALIGN_BYTES);
      localparam int ODD = ALIGN_BYTES >> TZ;
      localparam logic [fbfs_pkg::ADDR_W-1:0] LOW_MASK =
          fbfs_pkg::ADDR_W'((longint'(1) << TZ) - 1);
      localparam logic [fbfs_pkg::ADDR_W-1:0] INV = odd_inverse(fbfs_pkg::ADDR_W'(ODD));
      localparam logic [fbfs_pkg::ADDR_W-1:0] LIMIT =
          fbfs_pkg::ADDR_W'(((longint'(1) << fbfs_pkg::ADDR_W) - 1) / longint'(ODD));

      logic [fbfs_pkg::ADDR_W-1:0] shifted, product;

      always_comb begin
        shifted   = addr_i >> TZ;
        product   = shifted * INV;
        aligned_d = ((addr_i & LOW_MASK) == '0) && (product <= LIMIT);
      end
    end
  endgenerate

  assign res_o = '{done: done_q, aligned: aligned_q};

endmodule

@@ rtl/fbfs_table.sv @@
// Block table memory: one write port, one registered read port.
// Entry layout from fbfs_pkg.
`timescale 1ns / 1ps

module fbfs_table #(
  parameter int DEPTH = fbfs_pkg::MAX_BLOCKS_DEF,
  parameter int AW    = $clog2(fbfs_pkg::MAX_BLOCKS_DEF)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  fbfs_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output fbfs_pkg::entry_t rdata_o
);

  fbfs_pkg::entry_t mem [DEPTH];
  fbfs_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fbfs_ctrl.sv @@
// Sequencer of the fit selector: command decode, table scan with one shared
// size compare unit, policy register, length and next-fit cursor. Uses fbfs_pkg.
`timescale 1ns / 1ps

module fbfs_ctrl #(
  parameter int MAX_BLOCKS = fbfs_pkg::MAX_BLOCKS_DEF,
  parameter int IDX_W      = $clog2(fbfs_pkg::MAX_BLOCKS_DEF),
  parameter int LEN_W      = $clog2(fbfs_pkg::MAX_BLOCKS_DEF + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbfs_pkg::POL_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fbfs_pkg::OP_W-1:0]      in_op_i,
  input  logic [fbfs_pkg::IDX_IN_W-1:0]  entry_index_i,
  input  logic [fbfs_pkg::SIZE_W-1:0]    entry_size_i,
  input  logic                           entry_free_i,
  input  logic [fbfs_pkg::ADDR_W-1:0]    entry_addr_i,
  input  logic [fbfs_pkg::LEN_IN_W-1:0]  new_length_i,
  input  logic [fbfs_pkg::SIZE_W-1:0]    request_size_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [fbfs_pkg::IDX_OUT_W-1:0] chosen_index_o,
  output logic                           align_start_o,
  output logic [fbfs_pkg::ADDR_W-1:0]    align_addr_o,
  input  fbfs_pkg::align_res_t           align_res_i,
  output logic                           tbl_we_o,
  output logic [IDX_W-1:0]               tbl_waddr_o,
  output fbfs_pkg::entry_t               tbl_wdata_o,
  output logic [IDX_W-1:0]               tbl_raddr_o,
  input  fbfs_pkg::entry_t               tbl_rdata_i
);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] nxt;
    nxt = LEN_W'(idx) + LEN_W'(1);
    return (nxt < len) ? nxt[IDX_W-1:0] : '0;
  endfunction

  function automatic logic [fbfs_pkg::IDX_OUT_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[fbfs_pkg::IDX_OUT_W-1:0];
  endfunction

  fbfs_pkg::state_e  state_q, state_d;
  fbfs_pkg::policy_e policy_q, policy_d;
  fbfs_pkg::op_e     op;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic              have_q, have_d;

  logic [fbfs_pkg::SIZE_W-1:0]    req_q, req_d;
  logic [fbfs_pkg::SIZE_W-1:0]    best_q, best_d;
  logic [IDX_W-1:0]               best_idx_q, best_idx_d;
  logic [IDX_W-1:0]               iss_idx_q, iss_idx_d;
  logic [IDX_W-1:0]               rd_idx_q, rd_idx_d;
  logic                           found_q, found_d;
  logic [fbfs_pkg::IDX_OUT_W-1:0] chosen_q, chosen_d;
  logic [IDX_W-1:0]               wr_idx_q, wr_idx_d;
  logic [fbfs_pkg::SIZE_W-1:0]    wr_size_q, wr_size_d;
  logic                           wr_free_q, wr_free_d;

  logic cand, take, stop_first;

  // shared compare unit on the entry read back
  always_comb begin
    cand = tbl_rdata_i.usable && (tbl_rdata_i.size >= req_q);
    case (policy_q)
      fbfs_pkg::POL_BEST:  take = cand && (!have_q || tbl_rdata_i.size < best_q);
      fbfs_pkg::POL_WORST: take = cand && (tbl_rdata_i.size > best_q);
      default:             take = cand;
    endcase
    stop_first = rd_vld_q && take &&
                 (policy_q == fbfs_pkg::POL_FIRST || policy_q == fbfs_pkg::POL_NEXT);
  end

  always_comb begin
    state_d    = state_q;
    policy_d   = policy_q;
    len_d      = len_q;
    cursor_d   = cursor_q;
    cnt_d      = cnt_q;
    rd_vld_d   = rd_vld_q;
    have_d     = have_q;
    req_d      = req_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    iss_idx_d  = iss_idx_q;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    chosen_d   = chosen_q;
    wr_idx_d   = wr_idx_q;
    wr_size_d  = wr_size_q;
    wr_free_d  = wr_free_q;
    op         = fbfs_pkg::op_e'(in_op_i);

    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    align_start_o = 1'b0;
    tbl_we_o      = 1'b0;

    if (cfg_we_i) begin
      policy_d = fbfs_pkg::policy_e'(cfg_wdata_i);
    end

    case (state_q)
      fbfs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            fbfs_pkg::OP_WRITE: begin
              if (32'(entry_index_i) < 32'(MAX_BLOCKS)) begin
                wr_idx_d      = IDX_W'(32'(entry_index_i));
                wr_size_d     = entry_size_i;
                wr_free_d     = entry_free_i;
                align_start_o = 1'b1;
                state_d       = fbfs_pkg::ST_ALIGN;
              end
            end
            fbfs_pkg::OP_LENGTH: begin
              len_d = (32'(new_length_i) > 32'(MAX_BLOCKS)) ? LEN_W'(MAX_BLOCKS)
                                                             : LEN_W'(32'(new_length_i));
            end
            fbfs_pkg::OP_FIND: begin
              req_d      = request_size_i;
              cnt_d      = '0;
              rd_vld_d   = 1'b0;
              have_d     = 1'b0;
              best_d     = '0;
              best_idx_d = '0;
              iss_idx_d  = (policy_q == fbfs_pkg::POL_NEXT && LEN_W'(cursor_q) < len_q)
                           ? cursor_q : '0;
              state_d    = fbfs_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      fbfs_pkg::ST_ALIGN: begin
        if (align_res_i.done) begin
          tbl_we_o = 1'b1;
          state_d  = fbfs_pkg::ST_IDLE;
        end
      end

      fbfs_pkg::ST_SCAN: begin
        if (rd_vld_q && take) begin
          have_d     = 1'b1;
          best_d     = tbl_rdata_i.size;
          best_idx_d = rd_idx_q;
        end
        if (stop_first) begin
          found_d  = 1'b1;
          chosen_d = out_idx(rd_idx_q);
          if (policy_q == fbfs_pkg::POL_NEXT) begin
            cursor_d = wrap_inc(rd_idx_q, len_q);
          end
          state_d = fbfs_pkg::ST_DONE;
        end else if (cnt_q == len_q && !rd_vld_q) begin
          found_d  = have_q;
          chosen_d = have_q ? out_idx(best_idx_q) : '0;
          state_d  = fbfs_pkg::ST_DONE;
        end else if (cnt_q != len_q) begin
          rd_vld_d  = 1'b1;
          rd_idx_d  = iss_idx_q;
          iss_idx_d = wrap_inc(iss_idx_q, len_q);
          cnt_d     = cnt_q + LEN_W'(1);
        end else begin
          rd_vld_d = 1'b0;
        end
      end

      fbfs_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = fbfs_pkg::ST_IDLE;
        end
      end

      default: state_d = fbfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fbfs_pkg::ST_IDLE;
      policy_q <= fbfs_pkg::POL_FIRST;
      len_q    <= '0;
      cursor_q <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      policy_q <= policy_d;
      len_q    <= len_d;
      cursor_q <= cursor_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      have_q   <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    iss_idx_q  <= iss_idx_d;
    rd_idx_q   <= rd_idx_d;
    found_q    <= found_d;
    chosen_q   <= chosen_d;
    wr_idx_q   <= wr_idx_d;
    wr_size_q  <= wr_size_d;
    wr_free_q  <= wr_free_d;
  end

  assign align_addr_o   = entry_addr_i;
  assign tbl_waddr_o    = wr_idx_q;
  assign tbl_wdata_o    = '{usable: wr_free_q && align_res_i.aligned, size: wr_size_q};
  assign tbl_raddr_o    = iss_idx_q;
  assign found_o        = found_q;
  assign chosen_index_o = chosen_q;

endmodule

@@ tb/sv/fbfs_checker.sv @@
// Checker for the free block fit selector: watches the config port and both streams,
// predicts each find result from its own copy of the table and compares in order.
// Depends on fbfs_pkg.
`timescale 1ns / 1ps

module fbfs_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fbfs_pkg::POL_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [fbfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [fbfs_pkg::OP_W-1:0]        s_axis_tuser_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [fbfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tuser_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import fbfs_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] index;
  } pick_t;

  pick_t                expected_picks[$];
  logic [SIZE_W-1:0]    blk_size [MAX_BLOCKS_DEF];
  logic                 blk_free [MAX_BLOCKS_DEF];
  logic [ADDR_W-1:0]    blk_addr [MAX_BLOCKS_DEF];
  logic [LEN_IN_W-1:0]  list_len;
  logic [IDX_IN_W-1:0]  next_cursor;
  policy_e              policy;
  int                   fails = 0;

  function automatic bit fits(input int i, input logic [SIZE_W-1:0] req);
    return blk_free[i] && (blk_size[i] >= req) && ((blk_addr[i] % ALIGN_BYTES_DEF) == 0);
  endfunction

  // Picks a block under the current policy; next fit also advances the cursor when it finds one.
  function automatic pick_t select_block(input logic [SIZE_W-1:0] req);
    pick_t             res;
    int                i;
    logic [SIZE_W-1:0] extreme;
    res     = '0;
    extreme = '0;
    case (policy)
      POL_NEXT: begin
        if (list_len != 0) begin
          i = (next_cursor < list_len) ? int'(next_cursor) : 0;
          for (int n = 0; n < int'(list_len); n++) begin
            if (!res.found && fits(i, req)) begin
              res.found   = 1'b1;
              res.index   = IDX_OUT_W'(i);
              next_cursor = IDX_IN_W'((i + 1 < int'(list_len)) ? i + 1 : 0);
            end
            i = (i + 1 < int'(list_len)) ? i + 1 : 0;
          end
        end
      end
      POL_BEST: begin
        for (int k = 0; k < int'(list_len); k++) begin
          if (fits(k, req) && (!res.found || blk_size[k] < extreme)) begin
            extreme   = blk_size[k];
            res.found = 1'b1;
            res.index = IDX_OUT_W'(k);
          end
        end
      end
      POL_WORST: begin
        // zero-size candidates never beat the initial zero
        for (int k = 0; k < int'(list_len); k++) begin
          if (fits(k, req) && blk_size[k] > extreme) begin
            extreme   = blk_size[k];
            res.found = 1'b1;
            res.index = IDX_OUT_W'(k);
          end
        end
      end
      default: begin
        for (int k = 0; k < int'(list_len); k++) begin
          if (!res.found && fits(k, req)) begin
            res.found = 1'b1;
            res.index = IDX_OUT_W'(k);
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report(input string what, input pick_t exp_p, input pick_t got);
    fails++;
    if (fails <= 10) begin
      $display("%t mismatch (%s): expected found=%0b index=%0d, got found=%0b index=%0d",
               $realtime, what, exp_p.found, exp_p.index, got.found, got.index);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t                got;
    pick_t                exp_p;
    logic [LEN_IN_W-1:0]  nlen;
    logic [IDX_IN_W-1:0]  eidx;
    if (!rst_ni) begin
      list_len    = '0;
      next_cursor = '0;
      policy      = POL_FIRST;
      expected_picks.delete();
    end else begin
      // result transaction first: it can only belong to an earlier find
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.found = m_axis_tuser_i;
        got.index = m_axis_tdata_i[IDX_OUT_W-1:0];
        if (expected_picks.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          exp_p = expected_picks.pop_front();
          if (got.found !== exp_p.found || got.index !== exp_p.index) begin
            report("result", exp_p, got);
          end
        end
      end
      if (cfg_we_i) begin
        policy = policy_e'(cfg_wdata_i);
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        case (s_axis_tuser_i)
          OP_WRITE: begin
            eidx           = s_axis_tdata_i[EIDX_LSB +: IDX_IN_W];
            blk_size[eidx] = s_axis_tdata_i[ESIZE_LSB +: SIZE_W];
            blk_free[eidx] = s_axis_tdata_i[EFREE_LSB];
            blk_addr[eidx] = s_axis_tdata_i[EADDR_LSB +: ADDR_W];
          end
          OP_LENGTH: begin
            nlen     = s_axis_tdata_i[NLEN_LSB +: LEN_IN_W];
            list_len = (nlen > MAX_BLOCKS_DEF) ? LEN_IN_W'(MAX_BLOCKS_DEF) : nlen;
          end
          OP_FIND: begin
            expected_picks.push_back(select_block(s_axis_tdata_i[REQ_LSB +: SIZE_W]));
          end
          default: ;
        endcase
      end
    end
    pending_o    <= expected_picks.size();
    fail_count_o <= fails;
  end

endmodule

@@ tb/sv/tb.sv @@
// Top of the free block fit selector testbench: clock, reset, stimulus and verdict.
// Depends on fbfs_pkg, free_block_fit_selector and fbfs_checker.
`timescale 1ns / 1ps

module tb;
  import fbfs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
  localparam int              ITEMS_PER_PHASE = 72;
  localparam int              IDLE_GUARD      = 100;
  localparam int              CYCLE_LIMIT     = 600000;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [POL_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  int                     fail_count;
  int                     pending;
  int                     cycle_count   = 0;
  int                     burst_left    = 0;
  int                     rx_mode       = 0;
  int                     rx_left       = 0;
  int                     rx_phase      = 0;

  free_block_fit_selector i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  fbfs_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: switches between always ready, random, sparse and periodic stalls
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ((rx_phase % 12) < 4);
    endcase
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [IDX_IN_W-1:0] eidx,
                           input logic [SIZE_W-1:0] esize, input logic efree,
                           input logic [ADDR_W-1:0] eaddr, input logic [LEN_IN_W-1:0] nlen,
                           input logic [SIZE_W-1:0] req);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tuser                          = op;
    s_axis_tdata                          = '0;
    s_axis_tdata[EIDX_LSB +: IDX_IN_W]    = eidx;
    s_axis_tdata[ESIZE_LSB +: SIZE_W]     = esize;
    s_axis_tdata[EFREE_LSB]               = efree;
    s_axis_tdata[EADDR_LSB +: ADDR_W]     = eaddr;
    s_axis_tdata[NLEN_LSB +: LEN_IN_W]    = nlen;
    s_axis_tdata[REQ_LSB +: SIZE_W]       = req;
    s_axis_tvalid                         = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic do_write(input logic [IDX_IN_W-1:0] idx, input logic [SIZE_W-1:0] sz,
                          input logic fr, input logic [ADDR_W-1:0] ad);
    push_item(OP_WRITE, idx, sz, fr, ad, LEN_IN_W'($urandom), $urandom);
  endtask

  task automatic do_length(input logic [LEN_IN_W-1:0] n);
    push_item(OP_LENGTH, IDX_IN_W'($urandom), $urandom, 1'($urandom), $urandom, n, $urandom);
  endtask

  task automatic do_find(input logic [SIZE_W-1:0] req);
    push_item(OP_FIND, IDX_IN_W'($urandom), $urandom, 1'($urandom), $urandom,
              LEN_IN_W'($urandom), req);
  endtask

  task automatic do_unused();
    push_item(OP_UNUSED, IDX_IN_W'($urandom), $urandom, 1'($urandom), $urandom,
              LEN_IN_W'($urandom), $urandom);
  endtask

  task automatic write_random_entry(input logic [IDX_IN_W-1:0] idx);
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ad;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: sz = $urandom_range(0, 300);
      6:                sz = '0;
      7:                sz = '1;
      default:          sz = $urandom;
    endcase
    ad = $urandom;
    if ($urandom_range(0, 4) != 0) ad = ad - (ad % ALIGN_BYTES_DEF);
    do_write(idx, sz, ($urandom_range(0, 3) != 0), ad);
  endtask

  // lets the block finish any write still in progress once no result is pending
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (IDLE_GUARD) @(negedge clk_i);
  endtask

  initial begin
    policy_e           plan [8];
    int                done_items;
    int                pick;
    logic [SIZE_W-1:0] req;
    logic [LEN_IN_W-1:0] nlen;
    plan = '{POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_NEXT, POL_FIRST, POL_WORST, POL_BEST};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        wait_idle();
        cfg_we_i    = 1'b1;
        cfg_wdata_i = plan[ph];
        @(negedge clk_i);
        cfg_we_i    = 1'b0;
      end
      case (ph)
        0: begin
          do_find('0);  // empty list after reset
          for (int k = 0; k < MAX_BLOCKS_DEF; k++) write_random_entry(IDX_IN_W'(k));
          do_length(7'd127);  // saturates
          do_unused();
          do_write(6'd0, '1, 1'b1, 32'hFFFF_FFF0);
          do_write(6'd63, '0, 1'b1, '0);
          do_write(6'd5, 32'd100, 1'b1, 32'h0000_0105);  // misaligned
          do_find('0);
          do_find('1);
          do_find(32'd100);
        end
        1: begin
          do_length(7'd0);
          do_find('0);
          do_length(7'd64);
          do_write(6'd40, '1, 1'b1, 32'h0000_0400);
          do_write(6'd63, '1, 1'b1, 32'h0000_07F0);
          repeat (3) do_find('1);  // cursor wraps after the last entry
          do_length(7'd20);  // cursor may sit past the end
          do_find('1);
          do_length(7'd64);
        end
        2: begin
          do_write(6'd10, 32'd50, 1'b1, 32'h0000_0200);
          do_write(6'd11, 32'd50, 1'b1, 32'h0000_0210);
          do_write(6'd12, 32'd49, 1'b1, 32'h0000_021F);
          do_find(32'd45);
          do_find(32'd50);
          do_find(32'd51);
        end
        3: begin
          do_length(7'd2);
          do_write(6'd0, '0, 1'b1, '0);
          do_write(6'd1, '0, 1'b1, 32'h0000_0010);
          do_find('0);  // only zero sizes: nothing chosen
          do_write(6'd1, 32'd7, 1'b1, 32'h0000_0010);
          do_find('0);
          do_length(7'd64);
        end
        default: ;
      endcase

      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          do_unused();
        end else begin
          done_items++;
          if (pick < 48) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: req = $urandom_range(0, 300);
              6:                req = '0;
              7:                req = '1;
              default:          req = $urandom;
            endcase
            do_find(req);
          end else if (pick < 88) begin
            write_random_entry(IDX_IN_W'($urandom_range(0, MAX_BLOCKS_DEF - 1)));
          end else begin
            case ($urandom_range(0, 9))
              0:       nlen = '0;
              1:       nlen = LEN_IN_W'($urandom_range(65, 127));
              2, 3, 4: nlen = LEN_IN_W'($urandom_range(1, 4));
              default: nlen = LEN_IN_W'($urandom_range(1, 64));
            endcase
            do_length(nlen);
          end
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
